[rtl/ibom_pkg.sv]
// ----------------------------------------------------------------------------
// ibom_pkg
// Types and constants shared by the in-flight branch outcome mimicker.
// ----------------------------------------------------------------------------
package ibom_pkg;

    localparam int LOG_ENTRIES  = 6;
    localparam int SEARCH_DEPTH = 8;
    localparam int TAG_BITS     = 16;

    localparam int RING_SIZE = 1 << LOG_ENTRIES;
    // Only the newest pushes can ever be searched; a search deeper than the
    // ring revisits entries that already lie in a nearer cell.
    localparam int CELLS     = (SEARCH_DEPTH < RING_SIZE) ? SEARCH_DEPTH : RING_SIZE;

    localparam int CNT_BITS  = 16;
    localparam int STAT_BITS = 32;

    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_RESOLVE = 1'b1;

    typedef struct packed {
        logic        command;
        logic [15:0] tag;
        logic        base_prediction;
        logic        taken;
        logic        hit_at_lookup;
        logic        prediction_at_lookup;
    } cmd_t;

    typedef struct packed {
        logic                 final_prediction;
        logic                 mimic_hit;
        logic [STAT_BITS-1:0] hit_total;
        logic [STAT_BITS-1:0] correct_total;
        logic [STAT_BITS-1:0] incorrect_total;
    } res_t;

    // One in-flight prediction held by a cell.
    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic                dir;
    } entry_t;

    // Search state passed from newer to older cell.
    typedef struct packed {
        logic hit;
        logic dir;
    } srch_t;

endpackage

[rtl/ibom_cell.sv]
// ----------------------------------------------------------------------------
// ibom_cell
// One slot of the in-flight chain: holds a tag and direction, shifts to the
// older neighbor on each push, and takes part in the newest-first search.
// ----------------------------------------------------------------------------
module ibom_cell
    import ibom_pkg::*;
(
    input  logic                clk,
    input  logic                shift_en,
    input  entry_t              shift_in,
    output entry_t              held,
    input  logic                active,
    input  logic [TAG_BITS-1:0] key,
    input  srch_t               chain_in,
    output srch_t               chain_out
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   match;

    assign entry_next = shift_en ? shift_in : entry_reg;

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign held  = entry_reg;
    assign match = active && (entry_reg.tag == key);

    // A newer match wins; otherwise this cell may override.
    always_comb
    begin
        chain_out.hit = chain_in.hit | match;
        if (!chain_in.hit && match)
        begin
            chain_out.dir = entry_reg.dir;
        end
        else
        begin
            chain_out.dir = chain_in.dir;
        end
    end

endmodule

[rtl/inflight_branch_outcome_mimicker.sv]
// ----------------------------------------------------------------------------
// inflight_branch_outcome_mimicker
// Overrides the base predictor's direction with the direction given to the
// same tag by a recent in-flight prediction, and keeps hit statistics.
// ----------------------------------------------------------------------------
//
//  channel | signals                     | transfer when        | carries
//  --------+-----------------------------+----------------------+---------------
//  cmd     | cmd_valid, cmd_stall, cmd   | valid && !stall      | predict/resolve
//  res     | res_valid, res_stall, res   | valid && !stall      | one result
//
//  Each command's result sits in the output register the cycle after its
//  transfer, so one command per cycle is sustained while res_stall is low. The
//  search ripples combinationally through the cell chain.
//  Reset clears the in-flight count, the statistics and the output valid; the
//  cell contents are not cleared and are masked by the in-flight count.
//  cmd_stall rises only while a result waits under res_stall.
//
module inflight_branch_outcome_mimicker
    import ibom_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    // Output register and handshake.
    logic res_valid_reg;
    logic res_valid_next;
    res_t res_reg;
    res_t res_next;
    logic accept;
    logic push;

    // Architectural state. The ring is kept only as deep as the search
    // reaches: cell i holds the i-th newest push.
    logic [CNT_BITS-1:0]  count_reg;
    logic [CNT_BITS-1:0]  count_next;
    logic [STAT_BITS-1:0] hit_cnt_reg;
    logic [STAT_BITS-1:0] hit_cnt_next;
    logic [STAT_BITS-1:0] ok_cnt_reg;
    logic [STAT_BITS-1:0] ok_cnt_next;
    logic [STAT_BITS-1:0] bad_cnt_reg;
    logic [STAT_BITS-1:0] bad_cnt_next;

    logic [TAG_BITS-1:0]  key;
    srch_t                link [CELLS+1];
    entry_t               held [CELLS];
    entry_t               push_entry;
    srch_t                found;

    assign cmd_stall = res_valid_reg && res_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign push      = accept && (cmd.command == CMD_PREDICT);

    assign key     = cmd.tag[TAG_BITS-1:0];
    assign link[0] = '{hit: 1'b0, dir: cmd.base_prediction};
    assign found   = link[CELLS];

    // Final direction is pushed as the newest entry.
    assign push_entry = '{tag: key, dir: found.dir};

    genvar gi;
    generate
        for (gi = 0; gi < CELLS; gi++)
        begin : g_cell
            logic   active;
            entry_t feed;

            // Only the newest min(count, depth) entries take part.
            assign active = (count_reg > CNT_BITS'(gi));

            if (gi == 0)
            begin : g_head
                assign feed = push_entry;
            end
            else
            begin : g_body
                assign feed = held[gi-1];
            end

            ibom_cell u_cell (
                .clk       (clk),
                .shift_en  (push),
                .shift_in  (feed),
                .held      (held[gi]),
                .active    (active),
                .key       (key),
                .chain_in  (link[gi]),
                .chain_out (link[gi+1])
            );
        end
    endgenerate

    // Next state for one command.
    always_comb
    begin
        count_next     = count_reg;
        hit_cnt_next   = hit_cnt_reg;
        ok_cnt_next    = ok_cnt_reg;
        bad_cnt_next   = bad_cnt_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;

        if (accept)
        begin
            res_valid_next = 1'b1;
            case (cmd.command)
                CMD_PREDICT:
                begin
                    if (found.hit)
                    begin
                        hit_cnt_next = hit_cnt_reg + STAT_BITS'(1);
                    end
                    if (count_reg != '1)
                    begin
                        count_next = count_reg + CNT_BITS'(1);
                    end
                end
                CMD_RESOLVE:
                begin
                    if (cmd.hit_at_lookup)
                    begin
                        if (cmd.taken == cmd.prediction_at_lookup)
                        begin
                            ok_cnt_next = ok_cnt_reg + STAT_BITS'(1);
                        end
                        else
                        begin
                            bad_cnt_next = bad_cnt_reg + STAT_BITS'(1);
                        end
                    end
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - CNT_BITS'(1);
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase

            // Resolve results report direction and hit as zero.
            res_next.final_prediction = (cmd.command == CMD_PREDICT) && found.dir;
            res_next.mimic_hit        = (cmd.command == CMD_PREDICT) && found.hit;
            res_next.hit_total        = hit_cnt_next;
            res_next.correct_total    = ok_cnt_next;
            res_next.incorrect_total  = bad_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            count_reg     <= '0;
            hit_cnt_reg   <= '0;
            ok_cnt_reg    <= '0;
            bad_cnt_reg   <= '0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            count_reg     <= count_next;
            hit_cnt_reg   <= hit_cnt_next;
            ok_cnt_reg    <= ok_cnt_next;
            bad_cnt_reg   <= bad_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Every transfer in produces a result in the next cycle.
    a_res_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_valid)
        else $error("no result after command transfer");

    // Nothing can match in an empty flight window.
    a_no_hit_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> !found.hit)
        else $error("search hit with no in-flight entry");

    // Hit counter moves exactly with predict hits.
    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (hit_cnt_reg == $past(hit_cnt_reg)
                    + STAT_BITS'($past(push && found.hit))))
        else $error("hit counter out of step with search");

    // A resolve leaves the chain contents untouched (head cell written once
    // anything is in flight).
    a_resolve_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.command == CMD_RESOLVE) && (count_reg != '0))
        |=> $stable(held[0]))
        else $error("chain shifted on resolve");

endmodule
